// File: design/fallback_route_sorter_macros.svh
// assertion macros for the route sorter, used by frs_back
// no dependencies; taken in by `include where assertions are written
`ifndef FALLBACK_ROUTE_SORTER_MACROS_SVH
`define FALLBACK_ROUTE_SORTER_MACROS_SVH

// a property checked on every rising edge outside reset
`define FRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// an implication checked on every rising edge outside reset
`define FRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/frs_pkg.sv
// types and constants of the fallback route sorter
// no dependencies; used by every module of the block
package frs_pkg;

  localparam int NODE_W = 4;
  localparam int TIER_W = 3;
  localparam int LAT_W  = 16;
  localparam int BW_W   = 20;
  localparam int RANK_W = 4;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STORE_LIMIT = 16;
  localparam int QDEPTH = 4;

  // tier penalty codes, lower sorts first
  typedef enum logic [1:0] {
    PEN_SAME   = 2'd0,
    PEN_HIGHER = 2'd1,
    PEN_LOWER  = 2'd2
  } penalty_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELF_NODE = 2'd0,
    REG_SELF_TIER = 2'd1,
    REG_LAT_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    B_RUN  = 1'b0,
    B_EMIT = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIER_W-1:0] tier;
    logic [LAT_W-1:0]  latency;
    logic [BW_W-1:0]   bandwidth;
    penalty_t          penalty;
  } route_t;

  // one classified transaction passed from front to back
  typedef struct packed {
    route_t route;
    logic   keep;
    logic   final_mark;
  } qent_t;

endpackage

// File: design/frs_front.sv
// front end: configuration registers, input handshake and candidate classification
// depends on frs_pkg
module frs_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frs_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            start,
  input  logic [frs_pkg::NODE_W-1:0]      in_cand_node,
  input  logic [frs_pkg::TIER_W-1:0]      in_target_tier,
  input  logic [frs_pkg::LAT_W-1:0]       in_latency_ns,
  input  logic [frs_pkg::BW_W-1:0]        in_bandwidth_mbps,
  input  logic                            in_final_candidate,
  input  logic                            q_full,
  input  logic                            run_done,
  output logic                            busy,
  output logic                            q_push,
  output frs_pkg::qent_t                  q_wdata
);

  logic [frs_pkg::NODE_W-1:0] self_node_r;
  logic [frs_pkg::TIER_W-1:0] self_tier_r;
  logic [frs_pkg::LAT_W-1:0]  lat_limit_r;
  logic                       hold_r;
  logic                       hold_nxt;
  logic                       accept;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_node_r <= '0;
      self_tier_r <= '0;
      lat_limit_r <= '1;
    end else if (cfg_we) begin
      case (frs_pkg::cfg_reg_t'(cfg_index))
        frs_pkg::REG_SELF_NODE: self_node_r <= cfg_data[frs_pkg::NODE_W-1:0];
        frs_pkg::REG_SELF_TIER: self_tier_r <= cfg_data[frs_pkg::TIER_W-1:0];
        frs_pkg::REG_LAT_LIMIT: lat_limit_r <= cfg_data[frs_pkg::LAT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: hold off while the queue is full, and after a final transaction until its list is out
  assign busy   = hold_r || q_full;
  assign accept = start && !busy;
  assign q_push = accept;

  always_comb begin
    hold_nxt = hold_r;
    if (run_done) hold_nxt = 1'b0;
    if (accept && in_final_candidate) hold_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  // classification: drop own node and slow targets, compute tier penalty
  always_comb begin
    q_wdata.route.node      = in_cand_node;
    q_wdata.route.tier      = in_target_tier;
    q_wdata.route.latency   = in_latency_ns;
    q_wdata.route.bandwidth = in_bandwidth_mbps;
    if (in_target_tier == self_tier_r) begin
      q_wdata.route.penalty = frs_pkg::PEN_SAME;
    end else if (in_target_tier > self_tier_r) begin
      q_wdata.route.penalty = frs_pkg::PEN_HIGHER;
    end else begin
      q_wdata.route.penalty = frs_pkg::PEN_LOWER;
    end
    q_wdata.keep       = (in_cand_node != self_node_r) && (in_latency_ns <= lat_limit_r);
    q_wdata.final_mark = in_final_candidate;
  end

endmodule

// File: design/frs_queue.sv
// short queue of classified transactions between front and back
// depends on frs_pkg
module frs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  frs_pkg::qent_t wdata,
  input  logic           pop,
  output frs_pkg::qent_t rdata,
  output logic           empty,
  output logic           full
);

  localparam int PW = $clog2(frs_pkg::QDEPTH);
  localparam int CW = $clog2(frs_pkg::QDEPTH + 1);

  frs_pkg::qent_t slot_r [frs_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(frs_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/frs_back.sv
// back end: insertion chain of sorted routes and result emission
// depends on frs_pkg and fallback_route_sorter_macros.svh
`include "fallback_route_sorter_macros.svh"

module frs_back #(
  parameter int CAP = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  frs_pkg::qent_t              q_rdata,
  output logic                        q_pop,
  output logic                        run_done,
  output logic                        out_valid,
  output logic [frs_pkg::NODE_W-1:0]  out_route_node,
  output logic [frs_pkg::TIER_W-1:0]  out_route_tier,
  output logic [frs_pkg::LAT_W-1:0]   out_route_latency,
  output logic [frs_pkg::BW_W-1:0]    out_route_bandwidth,
  output logic [frs_pkg::RANK_W-1:0]  out_rank,
  output logic                        out_last_route,
  output logic                        out_no_routes
);

  localparam int CW = $clog2(CAP + 1);
  localparam int KW = 2 + frs_pkg::LAT_W + frs_pkg::BW_W;

  frs_pkg::back_state_t       state_r, state_nxt;
  frs_pkg::route_t            slot_r [CAP];
  frs_pkg::route_t            slot_nxt [CAP];
  logic [CW-1:0]              count_r, count_nxt;
  logic [frs_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic [CAP-1:0]             lt;
  logic [KW-1:0]              new_key;
  logic                       ins;
  logic [CW-1:0]              cnt_after;

  logic                       out_valid_r, out_valid_nxt;
  frs_pkg::route_t            out_route_r, out_route_nxt;
  logic [frs_pkg::RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_none_r, out_none_nxt;

  // sort key: penalty, then latency, smaller first; bandwidth inverted so higher wins
  assign new_key = {q_rdata.route.penalty, q_rdata.route.latency, ~q_rdata.route.bandwidth};

  // per-slot compare: new candidate strictly ahead of the stored one
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      lt[i] = (CW'(i) < count_r) &&
              (new_key < {slot_r[i].penalty, slot_r[i].latency, ~slot_r[i].bandwidth});
    end
  end

  assign q_pop     = (state_r == frs_pkg::B_RUN) && !q_empty;
  assign ins       = q_pop && q_rdata.keep && (count_r < CW'(CAP));
  assign cnt_after = count_r + CW'(ins);

  // slot moves: insert with shift toward the tail, or drain toward the head
  always_comb begin
    slot_nxt = slot_r;
    if (state_r == frs_pkg::B_EMIT) begin
      for (int i = 0; i < CAP - 1; i++) slot_nxt[i] = slot_r[i + 1];
    end else if (ins) begin
      for (int i = 0; i < CAP; i++) begin
        if (lt[i] || (count_r == CW'(i))) slot_nxt[i] = q_rdata.route;
      end
      for (int i = 1; i < CAP; i++) begin
        if (lt[i - 1]) slot_nxt[i] = slot_r[i - 1];
      end
    end
  end

  // sequencer: next state and result register contents
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cnt_after;
    rank_nxt      = rank_r;
    run_done      = 1'b0;
    out_valid_nxt = 1'b0;
    out_route_nxt = slot_r[0];
    out_rank_nxt  = rank_r;
    out_last_nxt  = 1'b0;
    out_none_nxt  = 1'b0;
    case (state_r)
      frs_pkg::B_RUN: begin
        if (q_pop && q_rdata.final_mark) begin
          rank_nxt = '0;
          if (cnt_after == '0) begin
            out_valid_nxt = 1'b1;
            out_route_nxt = '0;
            out_rank_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_none_nxt  = 1'b1;
            run_done      = 1'b1;
          end else begin
            state_nxt = frs_pkg::B_EMIT;
          end
        end
      end
      frs_pkg::B_EMIT: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = (count_r == CW'(1));
        count_nxt     = count_r - CW'(1);
        rank_nxt      = rank_r + frs_pkg::RANK_W'(1);
        if (count_r == CW'(1)) begin
          state_nxt = frs_pkg::B_RUN;
          run_done  = 1'b1;
        end
      end
      default: begin
        state_nxt = frs_pkg::B_RUN;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frs_pkg::B_RUN;
      count_r     <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // route slots and result payload
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    out_route_r <= out_route_nxt;
    out_rank_r  <= out_rank_nxt;
    out_last_r  <= out_last_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_route_node      = out_route_r.node;
  assign out_route_tier      = out_route_r.tier;
  assign out_route_latency   = out_route_r.latency;
  assign out_route_bandwidth = out_route_r.bandwidth;
  assign out_rank            = out_rank_r;
  assign out_last_route      = out_last_r;
  assign out_no_routes       = out_none_r;

  // checks
  `FRS_ASSERT(a_count_cap, clk, rst_n, count_r <= CW'(CAP), "route count above capacity")
  `FRS_ASSERT_IMP(a_emit_nonempty, clk, rst_n, state_r == frs_pkg::B_EMIT, count_r != '0, "emit with empty store")
  `FRS_ASSERT_IMP(a_none_is_last, clk, rst_n, out_valid_r && out_none_r, out_last_r && out_rank_r == '0, "empty marker not alone")
  `FRS_ASSERT_IMP(a_done_clears, clk, rst_n, run_done, ##1 (count_r == '0 && state_r == frs_pkg::B_RUN), "store not empty after run")

endmodule

// File: design/fallback_route_sorter.sv
// top level of the fallback route sorter: front, queue and back
// depends on frs_pkg, frs_front, frs_queue, frs_back
//
//   channel  handshake          payload
//   input    start / busy       in_cand_node .. in_final_candidate
//   result   out_valid strobe   out_route_node .. out_no_routes
//   config   cfg_we             cfg_index, cfg_data
//
// one transaction per cycle is taken while busy is low; the back pops it the
// next cycle, so the queue holds at most one entry while a list is built.
// a final transaction holds busy high until run_done ends its list;
// its first result passes the queue entry, B_EMIT state and result registers;
// the rest follow one per cycle; an empty list's marker skips B_EMIT.
// results are strobed for one cycle each; the receiver cannot stall.
// rst_n is synchronous; the route slots themselves are not cleared.
module fallback_route_sorter #(
  parameter int MAX_NODES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frs_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [frs_pkg::NODE_W-1:0]      in_cand_node,
  input  logic [frs_pkg::TIER_W-1:0]      in_target_tier,
  input  logic [frs_pkg::LAT_W-1:0]       in_latency_ns,
  input  logic [frs_pkg::BW_W-1:0]        in_bandwidth_mbps,
  input  logic                            in_final_candidate,
  output logic                            out_valid,
  output logic [frs_pkg::NODE_W-1:0]      out_route_node,
  output logic [frs_pkg::TIER_W-1:0]      out_route_tier,
  output logic [frs_pkg::LAT_W-1:0]       out_route_latency,
  output logic [frs_pkg::BW_W-1:0]        out_route_bandwidth,
  output logic [frs_pkg::RANK_W-1:0]      out_rank,
  output logic                            out_last_route,
  output logic                            out_no_routes
);

  localparam int CAP = (MAX_NODES < frs_pkg::STORE_LIMIT) ? MAX_NODES : frs_pkg::STORE_LIMIT;

  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  logic           run_done;
  frs_pkg::qent_t q_wdata;
  frs_pkg::qent_t q_rdata;

  // accept and classify
  frs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .in_cand_node       (in_cand_node),
    .in_target_tier     (in_target_tier),
    .in_latency_ns      (in_latency_ns),
    .in_bandwidth_mbps  (in_bandwidth_mbps),
    .in_final_candidate (in_final_candidate),
    .q_full             (q_full),
    .run_done           (run_done),
    .busy               (busy),
    .q_push             (q_push),
    .q_wdata            (q_wdata)
  );

  // decoupling queue
  frs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  // sort and emit
  frs_back #(
    .CAP (CAP)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .run_done            (run_done),
    .out_valid           (out_valid),
    .out_route_node      (out_route_node),
    .out_route_tier      (out_route_tier),
    .out_route_latency   (out_route_latency),
    .out_route_bandwidth (out_route_bandwidth),
    .out_rank            (out_rank),
    .out_last_route      (out_last_route),
    .out_no_routes       (out_no_routes)
  );

endmodule

// File: test/route_sort_tb_pkg.sv
// expected-route tracker for the fallback route sorter testbench
// depends on frs_pkg for widths, penalty codes and register indexes
`timescale 1ns / 100ps

package route_sort_tb_pkg;
  import frs_pkg::*;

  // one candidate transaction as driven on the input channel
  typedef struct packed {
    logic [NODE_W-1:0] cand_node;
    logic [TIER_W-1:0] target_tier;
    logic [LAT_W-1:0]  latency;
    logic [BW_W-1:0]   bandwidth;
    logic              final_mark;
  } cand_t;

  // one entry of the sorted fallback list
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIER_W-1:0] tier;
    logic [LAT_W-1:0]  latency;
    logic [BW_W-1:0]   bandwidth;
  } kept_route_t;

  // one result transaction as seen on the output channel
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIER_W-1:0] tier;
    logic [LAT_W-1:0]  latency;
    logic [BW_W-1:0]   bandwidth;
    logic [RANK_W-1:0] rank;
    logic              last_route;
    logic              no_routes;
  } route_result_t;

  class route_list_tracker;
    logic [NODE_W-1:0] self_node;
    logic [TIER_W-1:0] self_tier;
    logic [LAT_W-1:0]  latency_limit;
    kept_route_t       held_routes[$];
    route_result_t     expected_routes[$];
    int                mismatch_count;

    function new();
      self_node      = '0;
      self_tier      = '0;
      latency_limit  = '1;
      mismatch_count = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SELF_NODE: self_node = data[NODE_W-1:0];
        REG_SELF_TIER: self_tier = data[TIER_W-1:0];
        REG_LAT_LIMIT: latency_limit = data[LAT_W-1:0];
        default: ;
      endcase
    endfunction

    function penalty_t tier_penalty(logic [TIER_W-1:0] t);
      if (t == self_tier) return PEN_SAME;
      return (t > self_tier) ? PEN_HIGHER : PEN_LOWER;
    endfunction

    // strictly ahead: penalty, then lower latency, then higher bandwidth
    function bit goes_ahead(kept_route_t a, kept_route_t b);
      penalty_t pa;
      penalty_t pb;
      pa = tier_penalty(a.tier);
      pb = tier_penalty(b.tier);
      if (pa != pb) return pa < pb;
      if (a.latency != b.latency) return a.latency < b.latency;
      return a.bandwidth > b.bandwidth;
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction

    // place an accepted candidate; a closing one releases the whole list
    function void note_candidate(cand_t c);
      kept_route_t   r;
      route_result_t res;
      int            pos;
      r.node      = c.cand_node;
      r.tier      = c.target_tier;
      r.latency   = c.latency;
      r.bandwidth = c.bandwidth;
      if (c.cand_node != self_node && c.latency <= latency_limit &&
          held_routes.size() < STORE_LIMIT) begin
        pos = held_routes.size();
        // equal keys stay behind earlier arrivals
        while (pos > 0 && goes_ahead(r, held_routes[pos-1])) pos--;
        held_routes.insert(pos, r);
      end
      if (!c.final_mark) return;
      if (held_routes.size() == 0) begin
        res = '0;
        res.last_route = 1'b1;
        res.no_routes  = 1'b1;
        expected_routes.push_back(res);
        return;
      end
      for (int i = 0; i < held_routes.size(); i++) begin
        res.node       = held_routes[i].node;
        res.tier       = held_routes[i].tier;
        res.latency    = held_routes[i].latency;
        res.bandwidth  = held_routes[i].bandwidth;
        res.rank       = i[RANK_W-1:0];
        res.last_route = (i == held_routes.size() - 1);
        res.no_routes  = 1'b0;
        expected_routes.push_back(res);
      end
      held_routes.delete();
    endfunction

    // compare a strobed result with the oldest expected route
    function void check_route(route_result_t got);
      route_result_t want;
      if (expected_routes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected: node %0d tier %0d lat %0d bw %0d rank %0d last %0b none %0b",
                   got.node, got.tier, got.latency, got.bandwidth, got.rank,
                   got.last_route, got.no_routes);
        return;
      end
      want = expected_routes.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("expected: node %0d tier %0d lat %0d bw %0d rank %0d last %0b none %0b",
                   want.node, want.tier, want.latency, want.bandwidth, want.rank,
                   want.last_route, want.no_routes);
          $display("actual:   node %0d tier %0d lat %0d bw %0d rank %0d last %0b none %0b",
                   got.node, got.tier, got.latency, got.bandwidth, got.rank,
                   got.last_route, got.no_routes);
        end
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
// top-level testbench of the fallback route sorter: stimulus, monitors, end of run
// depends on frs_pkg, route_sort_tb_pkg and fallback_route_sorter
`timescale 1ns / 100ps

module tb_top;
  import frs_pkg::*;
  import route_sort_tb_pkg::*;

  localparam int ITEM_TOTAL    = 410;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = QDEPTH + STORE_LIMIT + 4;
  localparam int CYCLE_LIMIT   = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [NODE_W-1:0]    in_cand_node = '0;
  logic [TIER_W-1:0]    in_target_tier = '0;
  logic [LAT_W-1:0]     in_latency_ns = '0;
  logic [BW_W-1:0]      in_bandwidth_mbps = '0;
  logic                 in_final_candidate = 1'b0;
  logic                 out_valid;
  logic [NODE_W-1:0]    out_route_node;
  logic [TIER_W-1:0]    out_route_tier;
  logic [LAT_W-1:0]     out_route_latency;
  logic [BW_W-1:0]      out_route_bandwidth;
  logic [RANK_W-1:0]    out_rank;
  logic                 out_last_route;
  logic                 out_no_routes;

  route_list_tracker routes = new();
  int                items_sent = 0;
  int                cycle_count = 0;

  fallback_route_sorter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .busy               (busy),
    .in_cand_node       (in_cand_node),
    .in_target_tier     (in_target_tier),
    .in_latency_ns      (in_latency_ns),
    .in_bandwidth_mbps  (in_bandwidth_mbps),
    .in_final_candidate (in_final_candidate),
    .out_valid          (out_valid),
    .out_route_node     (out_route_node),
    .out_route_tier     (out_route_tier),
    .out_route_latency  (out_route_latency),
    .out_route_bandwidth(out_route_bandwidth),
    .out_rank           (out_rank),
    .out_last_route     (out_last_route),
    .out_no_routes      (out_no_routes)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fallback_route_sorter verification failed");
      $finish;
    end
  end

  // check results first, then record the input transaction of this edge
  always @(posedge clk) begin : monitor
    route_result_t got;
    cand_t         seen;
    if (rst_n) begin
      if (out_valid) begin
        got.node       = out_route_node;
        got.tier       = out_route_tier;
        got.latency    = out_route_latency;
        got.bandwidth  = out_route_bandwidth;
        got.rank       = out_rank;
        got.last_route = out_last_route;
        got.no_routes  = out_no_routes;
        routes.check_route(got);
      end
      if (start && !busy) begin
        seen.cand_node   = in_cand_node;
        seen.target_tier = in_target_tier;
        seen.latency     = in_latency_ns;
        seen.bandwidth   = in_bandwidth_mbps;
        seen.final_mark  = in_final_candidate;
        routes.note_candidate(seen);
      end
    end
  end

  // drive one candidate and hold it until accepted, then maybe idle
  task automatic send_candidate(cand_t c);
    in_cand_node       <= c.cand_node;
    in_target_tier     <= c.target_tier;
    in_latency_ns      <= c.latency;
    in_bandwidth_mbps  <= c.bandwidth;
    in_final_candidate <= c.final_mark;
    start              <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (items_sent < ITEM_TOTAL - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // stop sending and let every expected route drain out
  task automatic settle();
    start <= 1'b0;
    while (routes.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all three registers; unused upper data bits carry noise
  task automatic load_settings(logic [NODE_W-1:0] node, logic [TIER_W-1:0] tier,
                               logic [LAT_W-1:0] limit);
    logic [CFG_W-1:0] node_word;
    logic [CFG_W-1:0] tier_word;
    node_word = (CFG_W'($urandom()) & 16'hFFF0) | CFG_W'(node);
    tier_word = (CFG_W'($urandom()) & 16'hFFF8) | CFG_W'(tier);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SELF_NODE;
    cfg_data  <= node_word;
    routes.set_register(REG_SELF_NODE, node_word);
    @(negedge clk);
    cfg_index <= REG_SELF_TIER;
    cfg_data  <= tier_word;
    routes.set_register(REG_SELF_TIER, tier_word);
    @(negedge clk);
    cfg_index <= REG_LAT_LIMIT;
    cfg_data  <= limit;
    routes.set_register(REG_LAT_LIMIT, limit);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random candidate aimed at the drop boundaries and at key ties
  function automatic cand_t make_candidate(bit closing);
    cand_t c;
    int    lim;
    int    pick;
    lim = routes.latency_limit;
    if ($urandom_range(0, 9) == 0) begin
      // noise: anything, closing mark included
      c.cand_node   = 4'($urandom_range(0, 15));
      c.target_tier = 3'($urandom_range(0, 7));
      c.latency     = 16'($urandom_range(0, 65535));
      c.bandwidth   = 20'($urandom_range(0, 20'hFFFFF));
      c.final_mark  = 1'($urandom_range(0, 1));
      return c;
    end
    c.cand_node   = ($urandom_range(0, 7) == 0) ? routes.self_node : 4'($urandom_range(0, 15));
    c.target_tier = ($urandom_range(0, 2) == 0) ? routes.self_tier : 3'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0: c.latency = '0;
      1: c.latency = 16'(lim);
      2: c.latency = (lim == 65535) ? 16'(lim) : 16'(lim + 1);
      3, 4: begin
        pick = $urandom_range(0, 2);
        c.latency = (pick == 0) ? 16'd0 : (pick == 1) ? 16'(lim / 2) : 16'(lim);
      end
      5: c.latency = 16'($urandom_range(0, lim));
      default: c.latency = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 4))
      0: c.bandwidth = '0;
      1: c.bandwidth = 20'hFFFFF;
      2: c.bandwidth = 20'($urandom_range(0, 3));
      default: c.bandwidth = 20'($urandom_range(0, 20'hFFFFF));
    endcase
    c.final_mark = closing;
    return c;
  endfunction

  // stimulus and end of run
  initial begin
    int list_len;
    bit first_long;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: own entry alone gives the empty marker
    send_candidate('{4'd0, 3'd0, 16'd0, 20'd0, 1'b1});
    // extremes, an exact tie and the bandwidth tie-break
    send_candidate('{4'd15, 3'd7, 16'hFFFF, 20'hFFFFF, 1'b0});
    send_candidate('{4'd1, 3'd0, 16'd0, 20'd0, 1'b0});
    send_candidate('{4'd2, 3'd0, 16'd0, 20'd0, 1'b0});
    send_candidate('{4'd3, 3'd0, 16'd0, 20'hFFFFF, 1'b0});
    send_candidate('{4'd4, 3'd0, 16'd100, 20'd500, 1'b1});

    settle();
    load_settings(4'd9, 3'd3, 16'd1000);
    // own id, over the limit, at the limit, all three penalties, duplicates
    send_candidate('{4'd9, 3'd3, 16'd5, 20'd7, 1'b0});
    send_candidate('{4'd5, 3'd3, 16'd1001, 20'd9, 1'b0});
    send_candidate('{4'd6, 3'd3, 16'd1000, 20'd9, 1'b0});
    send_candidate('{4'd7, 3'd5, 16'd0, 20'd1, 1'b0});
    send_candidate('{4'd8, 3'd1, 16'd0, 20'd1, 1'b0});
    send_candidate('{4'd4, 3'd3, 16'd5, 20'd7, 1'b0});
    send_candidate('{4'd4, 3'd3, 16'd5, 20'd7, 1'b0});
    send_candidate('{4'd10, 3'd3, 16'd1000, 20'd20, 1'b1});
    // a list whose only candidate is dropped
    send_candidate('{4'd11, 3'd2, 16'd1001, 20'd0, 1'b1});

    settle();
    load_settings(4'd15, 3'd7, 16'd0);
    // zero limit, top tier; the closing transaction itself is dropped
    send_candidate('{4'd0, 3'd7, 16'd0, 20'd0, 1'b0});
    send_candidate('{4'd1, 3'd7, 16'd1, 20'd0, 1'b0});
    send_candidate('{4'd2, 3'd0, 16'd0, 20'hFFFFF, 1'b0});
    send_candidate('{4'd15, 3'd7, 16'd0, 20'd5, 1'b1});

    settle();
    load_settings(4'd6, 3'd4, 16'hFFFF);

    // random lists; the first one is long enough to overflow the store
    first_long = 1'b1;
    while (items_sent < ITEM_TOTAL) begin
      if (!first_long && items_sent < ITEM_TOTAL - CALM_ITEMS &&
          $urandom_range(0, 3) == 0) begin
        settle();
        load_settings(4'($urandom_range(0, 15)),
                      ($urandom_range(0, 3) == 0) ? 3'd0 :
                      ($urandom_range(0, 2) == 0) ? 3'd7 : 3'($urandom_range(0, 7)),
                      ($urandom_range(0, 5) == 0) ? 16'd0 :
                      ($urandom_range(0, 4) == 0) ? 16'hFFFF :
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) :
                      16'($urandom_range(0, 65535)));
      end else if (items_sent < ITEM_TOTAL - CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        settle();
      end
      if (first_long)
        list_len = 20;
      else if ($urandom_range(0, 9) == 0)
        list_len = $urandom_range(17, 22);
      else
        list_len = $urandom_range(1, 8);
      first_long = 1'b0;
      for (int k = 0; k < list_len; k++)
        send_candidate(make_candidate(k == list_len - 1));
    end

    start <= 1'b0;
    while (routes.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (routes.mismatch_count == 0 && routes.pending() == 0)
      $display("fallback_route_sorter verification clean");
    else
      $display("fallback_route_sorter verification failed");
    $finish;
  end

endmodule
